// ===== hdl/heq_pkg.sv =====
`default_nettype none

package heq_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_COUNT  = 2'd1,
		CMD_FINISH = 2'd2,
		CMD_MAP    = 2'd3
	} cmd_t;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	localparam logic [7:0] MAX_VALUE_RESET = 8'd255;

endpackage

`default_nettype wire

// ===== hdl/heq_ram.sv =====
`default_nettype none

module heq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                     clk,
	input  wire                     we,
	input  wire [$clog2(DEPTH)-1:0] waddr,
	input  wire [WIDTH-1:0]         wdata,
	input  wire [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read-first: a read at the written address returns the old word
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== hdl/heq_front.sv =====
`default_nettype none

module heq_front #(
	parameter int PIXEL_BITS = 8
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_ready,
	input  wire [1:0]             command,
	input  wire [7:0]             pixel,
	input  wire [7:0]             lim,
	input  wire                   sweeping,
	output logic                  q_valid,
	output heq_pkg::cmd_t         q_cmd,
	output logic [PIXEL_BITS-1:0] q_pix,
	input  wire                   q_pop
);

	import heq_pkg::*;

	localparam int IW = (PIXEL_BITS > 8) ? PIXEL_BITS : 8;

	cmd_t                  cmd_q [QUEUE_DEPTH];
	logic [PIXEL_BITS-1:0] pix_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_q;
	logic [QPTR_BITS-1:0]  rd_q;
	logic [QPTR_BITS:0]    cnt_q;

	logic [7:0]            pix_clamped;
	logic [IW-1:0]         pix_wide;
	logic                  push;

	assign pix_clamped = (pixel > lim) ? lim : pixel;
	assign pix_wide    = IW'(pix_clamped);

	assign in_ready = (cnt_q != (QPTR_BITS+1)'(QUEUE_DEPTH)) && !sweeping;
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != '0);
	assign q_cmd    = cmd_q[rd_q];
	assign q_pix    = pix_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			cmd_q[wr_q] <= cmd_t'(command);
			pix_q[wr_q] <= pix_wide[PIXEL_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (q_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (QPTR_BITS+1)'(push) - (QPTR_BITS+1)'(q_pop);
		end
	end

`ifndef SYNTHESIS
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_valid)
		else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire

// ===== hdl/heq_back.sv =====
`default_nettype none

module heq_back #(
	parameter int PIXEL_BITS = 8,
	parameter int COUNT_BITS = 22
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire [7:0]             lim,
	input  wire                   q_valid,
	input  heq_pkg::cmd_t         q_cmd,
	input  wire [PIXEL_BITS-1:0]  q_pix,
	output logic                  q_pop,
	output logic                  sweeping,
	output logic                  out_valid,
	input  wire                   out_ready,
	output logic [7:0]            mapped_value
);

	import heq_pkg::*;

	localparam int LEVELS = 1 << PIXEL_BITS;
	localparam int PW     = COUNT_BITS + 8;
	localparam int RW     = COUNT_BITS + 9;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_RUN,
		ST_FRD,
		ST_FADD,
		ST_FMUL,
		ST_FACC,
		ST_FDIV
	} state_t;

	state_t                state_q;
	logic [PIXEL_BITS-1:0] idx_q;
	logic [COUNT_BITS-1:0] total_q;
	logic                  table_ready_q;
	logic [COUNT_BITS-1:0] c_q;
	logic [COUNT_BITS-1:0] delta_q;
	logic [PW-1:0]         prod_q;
	logic [RW-1:0]         r_q;
	logic [7:0]            v_q;
	logic [7:0]            lim_q;

	logic                  cnt_s1;
	logic [PIXEL_BITS-1:0] cnt_addr_s1;
	logic                  map_s1;
	logic                  map_rdy_s1;

	logic                  lw_valid_q;
	logic [PIXEL_BITS-1:0] lw_addr_q;
	logic [COUNT_BITS-1:0] lw_data_q;

	logic [7:0]            omem_q [2];
	logic                  owr_q;
	logic                  ord_q;
	logic [1:0]            ocnt_q;

	logic                  bin_we;
	logic [PIXEL_BITS-1:0] bin_waddr;
	logic [COUNT_BITS-1:0] bin_wdata;
	logic [PIXEL_BITS-1:0] bin_raddr;
	logic [COUNT_BITS-1:0] bin_rdata;
	logic [COUNT_BITS-1:0] bin_old;
	logic [COUNT_BITS-1:0] bin_inc;

	logic                  map_we;
	logic [7:0]            map_rdata;

	logic                  depart;
	logic [2:0]            occ;
	logic                  map_room;
	logic                  div_step;
	logic [COUNT_BITS:0]   cum_sum;
	logic [COUNT_BITS-1:0] cum_new;
	logic [7:0]            push_data;

	assign sweeping = (state_q == ST_SWEEP);

	// output queue occupancy plus the map read in flight
	assign depart   = out_valid && out_ready;
	assign occ      = {1'b0, ocnt_q} + {2'b00, map_s1};
	assign map_room = (occ - {2'b00, depart}) < 3'd2;
	assign q_pop    = (state_q == ST_RUN) && q_valid && ((q_cmd != CMD_MAP) || map_room);

	// bin counts: count read-modify-write, clearing sweep, finish walk
	assign bin_raddr = (state_q == ST_RUN) ? q_pix : idx_q;
	assign bin_old   = (lw_valid_q && (lw_addr_q == cnt_addr_s1)) ? lw_data_q : bin_rdata;
	assign bin_inc   = (&bin_old) ? bin_old : bin_old + 1'b1;
	assign bin_we    = cnt_s1 || (state_q == ST_SWEEP);
	assign bin_waddr = cnt_s1 ? cnt_addr_s1 : idx_q;
	assign bin_wdata = cnt_s1 ? bin_inc : '0;

	heq_ram #(
		.WIDTH(COUNT_BITS),
		.DEPTH(LEVELS)
	) u_bin_ram (
		.clk  (clk),
		.we   (bin_we),
		.waddr(bin_waddr),
		.wdata(bin_wdata),
		.raddr(bin_raddr),
		.rdata(bin_rdata)
	);

	// running quotient: c*lim = v*total + r
	assign div_step = (total_q != '0) && (r_q >= RW'(total_q));
	assign cum_sum  = {1'b0, c_q} + {1'b0, bin_rdata};
	assign cum_new  = (cum_sum > {1'b0, total_q}) ? total_q : cum_sum[COUNT_BITS-1:0];
	assign map_we   = (state_q == ST_FDIV) && !div_step;

	heq_ram #(
		.WIDTH(8),
		.DEPTH(LEVELS)
	) u_map_ram (
		.clk  (clk),
		.we   (map_we),
		.waddr(idx_q),
		.wdata(v_q),
		.raddr(q_pix),
		.rdata(map_rdata)
	);

	always_ff @(posedge clk) begin
		cnt_addr_s1 <= q_pix;
		map_rdy_s1  <= table_ready_q;
		lw_addr_q   <= bin_waddr;
		lw_data_q   <= bin_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SWEEP;
			idx_q         <= '0;
			total_q       <= '0;
			table_ready_q <= 1'b0;
			c_q           <= '0;
			delta_q       <= '0;
			prod_q        <= '0;
			r_q           <= '0;
			v_q           <= '0;
			lim_q         <= '0;
			cnt_s1        <= 1'b0;
			map_s1        <= 1'b0;
			lw_valid_q    <= 1'b0;
		end else begin
			cnt_s1     <= q_pop && (q_cmd == CMD_COUNT);
			map_s1     <= q_pop && (q_cmd == CMD_MAP);
			lw_valid_q <= bin_we;
			unique case (state_q)
				ST_SWEEP: begin
					idx_q <= idx_q + 1'b1;
					if (&idx_q) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (q_pop) begin
						unique case (q_cmd)
							CMD_CLEAR: begin
								total_q       <= '0;
								table_ready_q <= 1'b0;
								idx_q         <= '0;
								state_q       <= ST_SWEEP;
							end
							CMD_COUNT: begin
								if (!(&total_q)) begin
									total_q <= total_q + 1'b1;
								end
							end
							CMD_FINISH: begin
								idx_q   <= '0;
								c_q     <= '0;
								r_q     <= '0;
								v_q     <= '0;
								lim_q   <= lim;
								state_q <= ST_FRD;
							end
							CMD_MAP: begin
							end
						endcase
					end
				end
				ST_FRD: begin
					state_q <= ST_FADD;
				end
				ST_FADD: begin
					c_q     <= cum_new;
					delta_q <= cum_new - c_q;
					state_q <= ST_FMUL;
				end
				ST_FMUL: begin
					prod_q  <= PW'(delta_q) * PW'(lim_q);
					state_q <= ST_FACC;
				end
				ST_FACC: begin
					r_q     <= r_q + RW'(prod_q);
					state_q <= ST_FDIV;
				end
				ST_FDIV: begin
					if (div_step) begin
						r_q <= r_q - RW'(total_q);
						v_q <= v_q + 1'b1;
					end else if (&idx_q) begin
						table_ready_q <= 1'b1;
						state_q       <= ST_RUN;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_FRD;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// two-entry result queue
	assign push_data    = map_rdy_s1 ? map_rdata : 8'd0;
	assign out_valid    = (ocnt_q != 2'd0);
	assign mapped_value = omem_q[ord_q];

	always_ff @(posedge clk) begin
		if (map_s1) begin
			omem_q[owr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (map_s1) begin
				owr_q <= ~owr_q;
			end
			if (depart) begin
				ord_q <= ~ord_q;
			end
			ocnt_q <= ocnt_q + {1'b0, map_s1} - {1'b0, depart};
		end
	end

`ifndef SYNTHESIS
	a_out_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(map_s1 && !depart) |-> (ocnt_q != 2'd2))
		else $error("result queue overflow");
	a_pop_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (state_q == ST_RUN))
		else $error("item taken outside run state");
	a_no_write_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s1 |-> (state_q != ST_SWEEP))
		else $error("count write during sweep");
	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FDIV) |-> (v_q <= lim_q))
		else $error("table entry above level limit");
`endif

endmodule

`default_nettype wire

// ===== hdl/histogram_equalizer.sv =====
// Histogram equalizer for one image channel.
// Input channel in_valid/in_ready carries command and pixel; result channel
// out_valid/out_ready carries mapped_value, one item per map command only.
// cfg_valid/cfg_ready writes max_value (always ready); write only when idle.
// Use: clear, count every pixel, finish, then map every pixel.
// Count and map items stream at one per cycle while the back end runs and, for
// map items, the result queue has room; a map result passes a four-entry command
// queue, a registered map memory read and a two-entry result queue.
// Clear keeps the back end busy to take it and then for the sweep over the bin
// memory, with in_ready low during the sweep.
// Finish walks every bin through the steps of the running quotient (read, add,
// multiply, accumulate, write), the write step repeating for each output level
// gained. Items queue up meanwhile.
// After reset the bin memory is swept with in_ready low, max_value is 255 and
// the table reads as zero until a finish.
// When the receiver stalls the result queue fills, map commands stop being
// taken from the command queue, and in_ready drops once that queue is full.
`default_nettype none

module histogram_equalizer #(
	parameter int PIXEL_BITS = 8,
	parameter int COUNT_BITS = 22
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [1:0]  command,
	input  wire [7:0]  pixel,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [7:0] mapped_value,
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire [7:0]  cfg_data
);

	import heq_pkg::*;

	localparam logic [7:0] TOP_LEVEL = (PIXEL_BITS >= 8) ? 8'hFF :
		8'((1 << PIXEL_BITS) - 1);

	logic [7:0]            max_value_q;
	logic [7:0]            lim;
	logic                  sweeping;
	logic                  q_valid;
	cmd_t                  q_cmd;
	logic [PIXEL_BITS-1:0] q_pix;
	logic                  q_pop;

	assign cfg_ready = 1'b1;
	assign lim       = (max_value_q > TOP_LEVEL) ? TOP_LEVEL : max_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_value_q <= MAX_VALUE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			max_value_q <= cfg_data;
		end
	end

	heq_front #(
		.PIXEL_BITS(PIXEL_BITS)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command (command),
		.pixel   (pixel),
		.lim     (lim),
		.sweeping(sweeping),
		.q_valid (q_valid),
		.q_cmd   (q_cmd),
		.q_pix   (q_pix),
		.q_pop   (q_pop)
	);

	heq_back #(
		.PIXEL_BITS(PIXEL_BITS),
		.COUNT_BITS(COUNT_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.lim         (lim),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd),
		.q_pix       (q_pix),
		.q_pop       (q_pop),
		.sweeping    (sweeping),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.mapped_value(mapped_value)
	);

endmodule

`default_nettype wire
